### rtl/ugb_pkg.sv
`default_nettype none
package ugb_pkg;

  localparam int MAX_CELLS = 4096;
  localparam int MAX_REFS  = 8192;
  localparam int ID_BITS   = 16;

  localparam int COORD_W = 32;
  localparam int DIM_W   = 4;
  localparam int NAXES   = 3;
  localparam int NCOORD  = 2 * NAXES;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 2;
  localparam int OBJ_W   = 16;
  localparam int IDX_W   = 13;
  localparam int DATA_W  = 16;
  localparam int CNT_W   = $clog2(MAX_REFS + 1);
  localparam int CELL_AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int SLOT_AW = $clog2(MAX_REFS);
  localparam int LIN_W   = NAXES * (DIM_W + 1);
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 32;
  localparam int DIMS_W  = NAXES * DIM_W;

  // stream payload layout
  localparam int IN_DW  = 224;  // object_id, six corners, index, zero pad
  localparam int OUT_DW = 32;   // data, count, zero pad

  localparam logic [CFG_IW-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SCALE_X  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SCALE_Y  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_SCALE_Z  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_DIMS     = 3'd6;

  localparam logic [COORD_W-1:0] SCALE_RST = 32'd65536;

  localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_COUNT     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FINISH    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_PLACE     = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ_CELL = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ_SLOT = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_CLR,
    S_MAP,
    S_WALK_INIT,
    S_WALK_RD,
    S_WALK_WR,
    S_FIN_RD,
    S_FIN_WR,
    S_RD,
    S_RD_WAIT,
    S_DONE
  } ugb_state_t;

  typedef struct packed {
    logic latch;
    logic clr_step;
    logic map_step;
    logic walk_init;
    logic walk_wr;
    logic fin_init;
    logic fin_wr;
    logic rd_capture;
    logic out_load;
  } ugb_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              clr_last;
    logic              map_last;
    logic              walk_empty;
    logic              walk_last;
    logic              fin_last;
  } ugb_sts_t;

  // coordinate slot (x_min .. z_max) to axis
  function automatic logic [1:0] axis_of(input logic [2:0] sel);
    logic [1:0] a;
    a = (sel >= 3'(NAXES)) ? 2'(sel - 3'(NAXES)) : sel[1:0];
    return a;
  endfunction

endpackage
`default_nettype wire

### rtl/uniform_grid_binning.sv
// One request is in work at a time. Read cell or slot does one store read; clear sweeps all
// MAX_CELLS counters; count and place map the six corners, then do one counter
// read-modify-write per covered cell; finish does one read and one write per active cell.
// The next request is taken only after the result is loaded into the output register.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, rst_n low) loads the register defaults and then sweeps the
// cell counters to zero; in_tready stays low during that pass.
`default_nettype none
module uniform_grid_binning import ugb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // configuration writes
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  // request channel
  input  logic              in_tvalid,
  output logic              in_tready,
  // object_id[15:0], x_min, y_min, z_min, x_max, y_max, z_max (32 each), index[220:208]
  input  logic [IN_DW-1:0]  in_tdata,
  // func
  input  logic [FUNC_W-1:0] in_tuser,
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  // data[15:0], count[29:16]
  output logic [OUT_DW-1:0] out_tdata,
  // status
  output logic [STAT_W-1:0] out_tuser
);

  ugb_cmd_t cmd;
  ugb_sts_t sts;

  // sequencer: one state per phase of a request
  ugb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cmd(cmd), .sts(sts)
  );

  // config, cell mapping (shared 32x32 multiplier), walk counters and the three stores
  ugb_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cmd(cmd), .sts(sts),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule
`default_nettype wire

### rtl/ugb_ram.sv
`default_nettype none
module ugb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/ugb_ctrl.sv
`default_nettype none
module ugb_ctrl import ugb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output ugb_cmd_t cmd,
  input  ugb_sts_t sts
);

  ugb_state_t state_r, state_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic       out_free;

  assign out_free   = !out_tvalid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts.func)
          FN_CLEAR:     state_nxt = S_CLR;
          FN_COUNT:     state_nxt = S_MAP;
          FN_PLACE:     state_nxt = S_MAP;
          FN_FINISH:    state_nxt = S_FIN_RD;
          FN_READ_CELL: state_nxt = S_RD;
          FN_READ_SLOT: state_nxt = S_RD;
          default:      state_nxt = S_DONE;
        endcase
      end
      S_CLR: begin
        if (sts.clr_last) state_nxt = S_DONE;
      end
      S_MAP: begin
        if (sts.map_last) state_nxt = S_WALK_INIT;
      end
      S_WALK_INIT: begin
        state_nxt = sts.walk_empty ? S_DONE : S_WALK_RD;
      end
      S_WALK_RD: state_nxt = S_WALK_WR;
      S_WALK_WR: begin
        state_nxt = sts.walk_last ? S_DONE : S_WALK_RD;
      end
      S_FIN_RD: state_nxt = S_FIN_WR;
      S_FIN_WR: begin
        state_nxt = sts.fin_last ? S_DONE : S_FIN_RD;
      end
      S_RD:      state_nxt = S_RD_WAIT;
      S_RD_WAIT: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd            = '0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      S_INIT:      cmd.clr_step = 1'b1;
      S_IDLE:      cmd.latch = in_tvalid;
      S_DISPATCH:  cmd.fin_init = 1'b1;
      S_CLR:       cmd.clr_step = 1'b1;
      S_MAP:       cmd.map_step = 1'b1;
      S_WALK_INIT: cmd.walk_init = 1'b1;
      S_WALK_WR:   cmd.walk_wr = 1'b1;
      S_FIN_WR:    cmd.fin_wr = 1'b1;
      S_RD_WAIT:   cmd.rd_capture = 1'b1;
      S_DONE: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_tvalid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/ugb_dp.sv
`default_nettype none
module ugb_dp import ugb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic [FUNC_W-1:0] in_tuser,
  input  ugb_cmd_t          cmd,
  output ugb_sts_t          sts,
  output logic [OUT_DW-1:0] out_tdata,
  output logic [STAT_W-1:0] out_tuser
);

  // configuration
  logic signed [COORD_W-1:0] org_r [NAXES];
  logic        [COORD_W-1:0] scl_r [NAXES];
  logic        [DIMS_W-1:0]  dims_r;

  // latched request
  logic        [FUNC_W-1:0]  func_r;
  logic        [ID_BITS-1:0] id_r;
  logic signed [COORD_W-1:0] coord_r [NCOORD];
  logic        [IDX_W-1:0]   index_r;
  logic        [STAT_W-1:0]  st_r;

  // mapping pipeline
  logic [2:0]         map_cnt_r;
  logic [COORD_W-1:0] d_r;
  logic               dpos_r;
  logic [2:0]         s1_sel_r;
  logic [COORD_W-1:0] ph_r;
  logic               ppos_r;
  logic [2:0]         s2_sel_r;
  logic [DIM_W-1:0]   bnd_r [NCOORD];

  // walk / sweep counters
  logic [DIM_W-1:0]   cx_r, cy_r, cz_r;
  logic [CELL_AW-1:0] clr_addr_r;
  logic [CELL_AW-1:0] fin_i_r;
  logic [CNT_W-1:0]   run_r;
  logic [CNT_W-1:0]   total_r;

  // results
  logic [STAT_W-1:0] res_st_r, out_st_r;
  logic [DATA_W-1:0] res_data_r, out_data_r;
  logic [CNT_W-1:0]  res_cnt_r, out_cnt_r;

  // memory ports
  logic               ctr_we, st_we, slot_we;
  logic [CELL_AW-1:0] ctr_waddr, cell_raddr;
  logic [CNT_W-1:0]   ctr_wdata, ctr_rd, start_rd;
  logic [ID_BITS-1:0] slot_rd;

  logic [DIM_W:0]     nx, ny, nz;
  logic [LIN_W-1:0]   active, act_raw, lin;
  logic               lin_ok, total_ok, s_ok, cell_in, slot_in;
  logic [CNT_W:0]     s_sum;
  logic signed [COORD_W:0] d_full;
  logic [2*COORD_W-1:0]    prod;
  logic [1:0]         ax1, ax2;
  logic [DIM_W-1:0]   n1, bound;

  function automatic logic [DIM_W-1:0] dim_m1(input logic [DIMS_W-1:0] dm,
                                               input logic [1:0] ax);
    logic [DIM_W-1:0] r;
    case (ax)
      2'd0:    r = dm[DIM_W-1:0];
      2'd1:    r = dm[2*DIM_W-1:DIM_W];
      default: r = dm[3*DIM_W-1:2*DIM_W];
    endcase
    return r;
  endfunction

  assign nx = {1'b0, dims_r[DIM_W-1:0]} + 1'b1;
  assign ny = {1'b0, dims_r[2*DIM_W-1:DIM_W]} + 1'b1;
  assign nz = {1'b0, dims_r[3*DIM_W-1:2*DIM_W]} + 1'b1;
  assign act_raw = LIN_W'(nx) * LIN_W'(ny) * LIN_W'(nz);
  assign active  = (act_raw > LIN_W'(MAX_CELLS)) ? LIN_W'(MAX_CELLS) : act_raw;

  assign lin    = (LIN_W'(cz_r) * LIN_W'(ny) + LIN_W'(cy_r)) * LIN_W'(nx) + LIN_W'(cx_r);
  assign lin_ok = lin < LIN_W'(MAX_CELLS);

  assign total_ok = total_r < CNT_W'(MAX_REFS);
  assign s_sum    = {1'b0, start_rd} + {1'b0, ctr_rd};
  assign s_ok     = s_sum < (CNT_W + 1)'(MAX_REFS);
  assign cell_in  = LIN_W'(index_r) < active;
  assign slot_in  = (IDX_W + 1)'(index_r) < (IDX_W + 1)'(MAX_REFS);

  // mapping stages: subtract, multiply, clamp
  assign ax1    = axis_of(s1_sel_r);
  assign ax2    = axis_of(s2_sel_r);
  assign d_full = (map_cnt_r < 3'(NCOORD))
                ? ({coord_r[map_cnt_r][COORD_W-1], coord_r[map_cnt_r]}
                   - {org_r[axis_of(map_cnt_r)][COORD_W-1], org_r[axis_of(map_cnt_r)]})
                : '0;
  assign prod   = (2*COORD_W)'(d_r) * (2*COORD_W)'(scl_r[ax1]);
  assign n1     = dim_m1(dims_r, ax2);
  assign bound  = !ppos_r ? '0 : ((ph_r > COORD_W'(n1)) ? n1 : ph_r[DIM_W-1:0]);

  always_comb begin
    case (func_r)
      FN_FINISH:    cell_raddr = fin_i_r;
      FN_READ_CELL: cell_raddr = index_r[CELL_AW-1:0];
      default:      cell_raddr = lin[CELL_AW-1:0];
    endcase
  end

  always_comb begin
    ctr_we    = 1'b0;
    ctr_waddr = lin[CELL_AW-1:0];
    ctr_wdata = '0;
    if (cmd.clr_step) begin
      ctr_we    = 1'b1;
      ctr_waddr = clr_addr_r;
    end else if (cmd.fin_wr) begin
      ctr_we    = 1'b1;
      ctr_waddr = fin_i_r;
    end else if (cmd.walk_wr) begin
      ctr_wdata = ctr_rd + 1'b1;
      ctr_we    = lin_ok && ((func_r == FN_PLACE) ? s_ok : total_ok);
    end
  end

  assign st_we   = cmd.fin_wr;
  assign slot_we = cmd.walk_wr && (func_r == FN_PLACE) && lin_ok && s_ok;

  ugb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CELLS)) u_ctr (
    .clk(clk), .we(ctr_we), .waddr(ctr_waddr), .wdata(ctr_wdata),
    .raddr(cell_raddr), .rdata(ctr_rd)
  );

  ugb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CELLS)) u_start (
    .clk(clk), .we(st_we), .waddr(fin_i_r), .wdata(run_r),
    .raddr(cell_raddr), .rdata(start_rd)
  );

  ugb_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_REFS)) u_slot (
    .clk(clk), .we(slot_we), .waddr(s_sum[SLOT_AW-1:0]), .wdata(id_r),
    .raddr(index_r[SLOT_AW-1:0]), .rdata(slot_rd)
  );

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NAXES; a++) begin
        org_r[a] <= '0;
        scl_r[a] <= SCALE_RST;
      end
      dims_r     <= '0;
      total_r    <= '0;
      clr_addr_r <= '0;
      map_cnt_r  <= '0;
      func_r     <= FN_CLEAR;
      st_r       <= ST_OK;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X: org_r[0] <= cfg_wdata;
          REG_ORIGIN_Y: org_r[1] <= cfg_wdata;
          REG_ORIGIN_Z: org_r[2] <= cfg_wdata;
          REG_SCALE_X:  scl_r[0] <= cfg_wdata;
          REG_SCALE_Y:  scl_r[1] <= cfg_wdata;
          REG_SCALE_Z:  scl_r[2] <= cfg_wdata;
          REG_DIMS:     dims_r   <= cfg_wdata[DIMS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.latch) begin
        func_r    <= in_tuser;
        st_r      <= ST_OK;
        map_cnt_r <= '0;
      end
      if (cmd.map_step) map_cnt_r <= map_cnt_r + 1'b1;
      if (cmd.clr_step) begin
        total_r    <= '0;
        clr_addr_r <= (clr_addr_r == CELL_AW'(MAX_CELLS - 1)) ? '0 : clr_addr_r + 1'b1;
      end
      if (cmd.walk_wr && lin_ok) begin
        if (func_r == FN_PLACE) begin
          if (!s_ok) st_r <= ST_FULL;
        end else if (total_ok) begin
          total_r <= total_r + 1'b1;
        end else begin
          st_r <= ST_FULL;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      id_r    <= in_tdata[ID_BITS-1:0];
      for (int k = 0; k < NCOORD; k++) begin
        coord_r[k] <= in_tdata[OBJ_W + k*COORD_W +: COORD_W];
      end
      index_r <= in_tdata[OBJ_W + NCOORD*COORD_W +: IDX_W];
    end
    if (cmd.map_step) begin
      d_r      <= d_full[COORD_W-1:0];
      dpos_r   <= !d_full[COORD_W] && (d_full != '0);
      s1_sel_r <= map_cnt_r;
      ph_r     <= prod[2*COORD_W-1:COORD_W];
      ppos_r   <= dpos_r;
      s2_sel_r <= s1_sel_r;
      if (map_cnt_r >= 3'd2) bnd_r[s2_sel_r] <= bound;
    end
    if (cmd.walk_init) begin
      cx_r <= bnd_r[0];
      cy_r <= bnd_r[1];
      cz_r <= bnd_r[2];
    end
    if (cmd.walk_wr) begin
      if (cx_r != bnd_r[3]) begin
        cx_r <= cx_r + 1'b1;
      end else begin
        cx_r <= bnd_r[0];
        if (cy_r != bnd_r[4]) begin
          cy_r <= cy_r + 1'b1;
        end else begin
          cy_r <= bnd_r[1];
          cz_r <= cz_r + 1'b1;
        end
      end
    end
    if (cmd.fin_init) begin
      fin_i_r <= '0;
      run_r   <= '0;
    end
    if (cmd.fin_wr) begin
      fin_i_r <= fin_i_r + 1'b1;
      run_r   <= run_r + ctr_rd;
    end
    if (cmd.rd_capture) begin
      res_st_r   <= ST_OK;
      res_data_r <= '0;
      res_cnt_r  <= '0;
      if (func_r == FN_READ_CELL) begin
        if (cell_in) begin
          res_data_r <= DATA_W'(start_rd);
          res_cnt_r  <= ctr_rd;
        end else begin
          res_st_r <= ST_RANGE;
        end
      end else if (slot_in) begin
        res_data_r <= DATA_W'(slot_rd);
      end else begin
        res_st_r <= ST_RANGE;
      end
    end
    if (cmd.out_load) begin
      out_st_r   <= ST_OK;
      out_data_r <= '0;
      out_cnt_r  <= '0;
      case (func_r)
        FN_COUNT: begin
          out_st_r  <= st_r;
          out_cnt_r <= total_r;
        end
        FN_FINISH: out_cnt_r <= total_r;
        FN_PLACE:  out_st_r <= st_r;
        FN_READ_CELL, FN_READ_SLOT: begin
          out_st_r   <= res_st_r;
          out_data_r <= res_data_r;
          out_cnt_r  <= res_cnt_r;
        end
        default: ;
      endcase
    end
  end

  assign sts.func       = func_r;
  assign sts.clr_last   = (clr_addr_r == CELL_AW'(MAX_CELLS - 1));
  assign sts.map_last   = (map_cnt_r == 3'(NCOORD + 1));
  assign sts.walk_empty = (bnd_r[3] < bnd_r[0]) || (bnd_r[4] < bnd_r[1])
                       || (bnd_r[5] < bnd_r[2]);
  assign sts.walk_last  = (cx_r == bnd_r[3]) && (cy_r == bnd_r[4]) && (cz_r == bnd_r[5]);
  assign sts.fin_last   = (LIN_W'(fin_i_r) == active - 1'b1);

  assign out_tdata = {(OUT_DW - DATA_W - CNT_W)'(0), out_cnt_r, out_data_r};
  assign out_tuser = out_st_r;

endmodule
`default_nettype wire

### rtl/ugb_checker.sv
`default_nettype none
module ugb_checker import ugb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic [STAT_W-1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK) || (out_tuser == ST_FULL) || (out_tuser == ST_RANGE))
    else $error("bad status code");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[DATA_W +: CNT_W] <= CNT_W'(MAX_REFS))
    else $error("count beyond reference store size");

endmodule

bind uniform_grid_binning ugb_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
`default_nettype wire

### tb/sv/ugb_checker.sv
`default_nettype none
module ugb_scoreboard import ugb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]  cfg_wdata,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [IN_DW-1:0]   in_tdata,
  input  logic [FUNC_W-1:0]  in_tuser,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [OUT_DW-1:0]  out_tdata,
  input  logic [STAT_W-1:0]  out_tuser,
  output int                 fails,
  output int                 pending,
  output logic [MAX_REFS-1:0] slot_filled
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
  } grid_result_t;

  grid_result_t results_due[$];

  logic signed [COORD_W-1:0] org [NAXES];
  logic [COORD_W-1:0]        scl [NAXES];
  logic [DIMS_W-1:0]         dims;
  logic [CNT_W-1:0]          bin_count [MAX_CELLS];
  logic [CNT_W-1:0]          bin_start [MAX_CELLS];
  logic [DATA_W-1:0]         slot_id [MAX_REFS];
  logic [CNT_W-1:0]          ref_sum;

  initial begin
    fails = 0;
    pending = 0;
  end

  function automatic int axis_bin(int ax, logic [COORD_W-1:0] raw, int n);
    longint     d;
    logic [63:0] p;
    d = longint'($signed(raw)) - longint'(org[ax]);
    if (d <= 0) return 0;
    p = (64'(d) * 64'(scl[ax])) >> 32;
    if (p > 64'(n - 1)) return n - 1;
    return int'(p);
  endfunction

  // count or scatter over the covered cells; returns status
  function automatic logic [STAT_W-1:0] bin_walk(logic [IN_DW-1:0] d, bit scatter);
    int n [NAXES];
    int lo [NAXES];
    int hi [NAXES];
    int c, s;
    logic [STAT_W-1:0] st;
    st = ST_OK;
    for (int a = 0; a < NAXES; a++) begin
      n[a]  = int'(dims[a*DIM_W +: DIM_W]) + 1;
      lo[a] = axis_bin(a, d[16 + a*32 +: 32], n[a]);
      hi[a] = axis_bin(a, d[112 + a*32 +: 32], n[a]);
    end
    for (int z = lo[2]; z <= hi[2]; z++)
      for (int y = lo[1]; y <= hi[1]; y++)
        for (int x = lo[0]; x <= hi[0]; x++) begin
          c = (z * n[1] + y) * n[0] + x;
          if (c >= MAX_CELLS) continue;
          if (scatter) begin
            s = int'(bin_start[c]) + int'(bin_count[c]);
            if (s < MAX_REFS) begin
              slot_id[s] = d[15:0];
              slot_filled[s] = 1'b1;
              bin_count[c]++;
            end else st = ST_FULL;
          end else if (ref_sum < MAX_REFS) begin
            bin_count[c]++;
            ref_sum++;
          end else st = ST_FULL;
        end
    return st;
  endfunction

  function automatic grid_result_t grid_predict(logic [FUNC_W-1:0] f, logic [IN_DW-1:0] d);
    grid_result_t r;
    int active, idx, run;
    r = '0;
    active = (int'(dims[3:0]) + 1) * (int'(dims[7:4]) + 1) * (int'(dims[11:8]) + 1);
    if (active > MAX_CELLS) active = MAX_CELLS;
    idx = int'(d[220:208]);
    case (f)
      FN_CLEAR: begin
        foreach (bin_count[i]) bin_count[i] = '0;
        ref_sum = '0;
      end
      FN_COUNT: begin
        r.status = bin_walk(d, 1'b0);
        r.count = ref_sum;
      end
      FN_FINISH: begin
        run = 0;
        for (int i = 0; i < active; i++) begin
          bin_start[i] = CNT_W'(run);
          run += int'(bin_count[i]);
          bin_count[i] = '0;
        end
        r.count = ref_sum;
      end
      FN_PLACE: r.status = bin_walk(d, 1'b1);
      FN_READ_CELL: begin
        if (idx < active) begin
          r.data = DATA_W'(bin_start[idx]);
          r.count = bin_count[idx];
        end else r.status = ST_RANGE;
      end
      FN_READ_SLOT: begin
        if (idx < MAX_REFS) r.data = slot_id[idx];
        else r.status = ST_RANGE;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    grid_result_t got, want;
    if (!rst_n) begin
      for (int a = 0; a < NAXES; a++) begin
        org[a] = '0;
        scl[a] = SCALE_RST;
      end
      dims = '0;
      foreach (bin_count[i]) bin_count[i] = '0;
      ref_sum = '0;
      slot_filled = '0;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X: org[0] = cfg_wdata;
          REG_ORIGIN_Y: org[1] = cfg_wdata;
          REG_ORIGIN_Z: org[2] = cfg_wdata;
          REG_SCALE_X:  scl[0] = cfg_wdata;
          REG_SCALE_Y:  scl[1] = cfg_wdata;
          REG_SCALE_Z:  scl[2] = cfg_wdata;
          REG_DIMS:     dims = cfg_wdata[DIMS_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        results_due.push_back(grid_predict(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.data = out_tdata[15:0];
        got.count = out_tdata[29:16];
        if (results_due.size() == 0) begin
          $error("unexpected result: status %0d data %0d count %0d",
                 got.status, got.data, got.count);
          fails++;
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
          end
          if (got.data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, got.data);
            fails++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            fails++;
          end
        end
      end
    end
    pending = results_due.size();
  end

endmodule
`default_nettype wire

### tb/sv/uniform_grid_binning_tb.sv
`default_nettype none
module uniform_grid_binning_tb;
  import ugb_pkg::*;

  // codes the block must treat as no-ops
  localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;
  localparam int STALL_LIMIT = 40000;  // idle cycles; longer than a finish or clear sweep
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 16;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;   // object_id, x/y/z_min, x/y/z_max, index
  logic [FUNC_W-1:0] in_tuser = '0;   // func
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;       // data, count
  logic [STAT_W-1:0] out_tuser;       // status

  int                  fails, pending;
  logic [MAX_REFS-1:0] slot_filled;

  // stimulus-side view of the grid setup
  logic [COORD_W-1:0] cur_org [NAXES];
  logic [COORD_W-1:0] cur_scl [NAXES];
  logic [DIMS_W-1:0]  cur_dims;

  bit no_idle = 1'b0;
  bit hold_kick = 1'b0, hold_seen = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  uniform_grid_binning dut (.*);

  ugb_scoreboard chk (.*);

  // result side: random back-pressure, plus one long hold on request
  always @(negedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= 35);
    end
  end

  // watchdog: any handshake on either channel counts as progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [IN_DW-1:0] pack_req(logic [15:0] id, logic [COORD_W-1:0] lo [NAXES],
                                                logic [COORD_W-1:0] hi [NAXES],
                                                logic [IDX_W-1:0] idx);
    logic [IN_DW-1:0] d;
    d = '0;
    d[15:0] = id;
    for (int a = 0; a < NAXES; a++) begin
      d[16 + a*32 +: 32] = lo[a];
      d[112 + a*32 +: 32] = hi[a];
    end
    d[220:208] = idx;
    return d;
  endfunction

  task automatic send_req(logic [FUNC_W-1:0] f, logic [IN_DW-1:0] d);
    if (!no_idle) begin
      while ($urandom_range(99) < 35) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= d;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    @(negedge clk);
  endtask

  task automatic send_idx(logic [FUNC_W-1:0] f, int idx);
    logic [IN_DW-1:0] d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    d[220:208] = IDX_W'(idx);
    d[IN_DW-1:221] = '0;
    send_req(f, d);
  endtask

  // registers only change with nothing in flight
  task automatic setup_grid(logic [COORD_W-1:0] o [NAXES], logic [COORD_W-1:0] s [NAXES],
                            logic [DIMS_W-1:0] dm);
    in_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    for (int a = 0; a < NAXES; a++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_ORIGIN_X + CFG_IW'(a);
      cfg_wdata <= o[a];
      @(negedge clk);
      cfg_index <= REG_SCALE_X + CFG_IW'(a);
      cfg_wdata <= s[a];
      @(negedge clk);
    end
    cfg_index <= REG_DIMS;
    cfg_wdata <= CFG_DW'(dm);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_org = o;
    cur_scl = s;
    cur_dims = dm;
    // every new grid starts with finish so all active starts are defined
    send_idx(FN_FINISH, 0);
  endtask

  function automatic int active_cells();
    int n;
    n = (int'(cur_dims[3:0]) + 1) * (int'(cur_dims[7:4]) + 1) * (int'(cur_dims[11:8]) + 1);
    return (n > MAX_CELLS) ? MAX_CELLS : n;
  endfunction

  // prefer slots already written by a place; falls back to slot 0
  function automatic int pick_slot();
    int idx;
    for (int t = 0; t < 40; t++) begin
      idx = (t < 20) ? $urandom_range(0, 63) : $urandom_range(0, MAX_REFS - 1);
      if (slot_filled[idx]) return idx;
    end
    return 0;
  endfunction

  // box mostly inside the grid, sometimes a point, sometimes raw noise
  task automatic make_box(output logic [COORD_W-1:0] lo [NAXES],
                          output logic [COORD_W-1:0] hi [NAXES]);
    longint span, b;
    int pick;
    pick = $urandom_range(99);
    for (int a = 0; a < NAXES; a++) begin
      span = ((longint'(cur_dims[a*DIM_W +: DIM_W]) + 1) << 32) /
             ((cur_scl[a] == 0) ? 1 : longint'(cur_scl[a]));
      if (span > (64'sd1 << 30)) span = 64'sd1 << 30;
      if (span < 2) span = 2;
      b = longint'($signed(cur_org[a])) - span / 8 + longint'($urandom_range(0, int'(span)));
      lo[a] = COORD_W'(b);
      hi[a] = (pick < 10) ? lo[a] : COORD_W'(b + longint'($urandom_range(0, int'(span / 2))));
      if (pick >= 93) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end
    end
  endtask

  initial begin
    logic [COORD_W-1:0] o [NAXES];
    logic [COORD_W-1:0] s [NAXES];
    logic [COORD_W-1:0] lo [NAXES];
    logic [COORD_W-1:0] hi [NAXES];
    logic [COORD_W-1:0] box_lo [$][NAXES];
    logic [COORD_W-1:0] box_hi [$][NAXES];
    logic [15:0] box_id [$];
    logic [DIMS_W-1:0] dm;
    int nb;

    for (int a = 0; a < NAXES; a++) begin
      cur_org[a] = '0;
      cur_scl[a] = SCALE_RST;
    end
    cur_dims = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed: reset grid of a single cell ----
    send_idx(FN_FINISH, 0);
    for (int a = 0; a < NAXES; a++) begin
      lo[a] = '0;
      hi[a] = '0;
    end
    send_req(FN_COUNT, pack_req(16'h0000, lo, lo, '0));     // point at origin
    for (int a = 0; a < NAXES; a++) hi[a] = 32'h7FFF_FFFF;
    send_req(FN_COUNT, pack_req(16'hFFFF, lo, hi, '0));
    send_req(FN_COUNT, pack_req(16'h1234, hi, lo, '0));     // max below min, but both corners clamp to cell 0
    send_idx(FN_FINISH, 0);
    send_req(FN_PLACE, pack_req(16'h0000, lo, lo, '0));
    send_req(FN_PLACE, pack_req(16'hFFFF, lo, hi, '0));
    send_idx(FN_READ_CELL, 0);
    send_idx(FN_READ_CELL, 1);                              // beyond active cells
    send_idx(FN_READ_CELL, 8191);
    send_idx(FN_READ_SLOT, 1);
    send_idx(FN_SPARE_A, 8191);
    send_idx(FN_SPARE_B, 0);
    send_idx(FN_CLEAR, 0);

    // ---- directed: full 16x16x16 grid, store overflow on count and place ----
    for (int a = 0; a < NAXES; a++) begin
      o[a] = 32'h8000_0000;
      s[a] = 32'hFFFF_FFFF;
      lo[a] = 32'h8000_0000;
      hi[a] = 32'h7FFF_FFFF;
    end
    setup_grid(o, s, 12'hFFF);
    repeat (3) send_req(FN_COUNT, pack_req(16'hA5A5, lo, hi, '0));
    send_idx(FN_FINISH, 0);
    repeat (3) send_req(FN_PLACE, pack_req(16'h5A5A, lo, hi, '0));
    send_idx(FN_READ_SLOT, MAX_REFS - 1);
    send_idx(FN_READ_CELL, MAX_CELLS - 1);

    // ---- directed: origin at the top, zero scale: all lands in cell 0 ----
    for (int a = 0; a < NAXES; a++) begin
      o[a] = 32'h7FFF_FFFF;
      s[a] = '0;
    end
    setup_grid(o, s, 12'h000);
    send_idx(FN_CLEAR, 0);
    send_req(FN_COUNT, pack_req(16'h0F0F, lo, hi, '0));
    send_idx(FN_FINISH, 0);

    // ---- random phases: count, finish, place the same boxes, read back ----
    for (int ph = 0; ph < PHASES; ph++) begin
      dm = {4'($urandom_range(0, 3)), 4'($urandom_range(0, 3)), 4'($urandom_range(0, 3))};
      if ($urandom_range(5) == 0) dm[$urandom_range(0, 2)*DIM_W +: DIM_W] = 4'hF;
      for (int a = 0; a < NAXES; a++) begin
        o[a] = COORD_W'($urandom_range(0, 1 << 22)) - (32'd1 << 21);
        case ($urandom_range(3))
          0: s[a] = SCALE_RST;
          1: s[a] = $urandom_range(1 << 12, 1 << 20);
          2: s[a] = $urandom;
          default: s[a] = SCALE_RST >> $urandom_range(0, 2);
        endcase
      end
      setup_grid(o, s, dm);
      // sender holds off until the result side has drained
      if (ph == 5) begin
        in_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      no_idle = (ph == 3);
      if (ph == 7) hold_kick = ~hold_kick;  // result side stalls while requests keep coming
      send_idx(FN_CLEAR, 0);
      box_lo.delete();
      box_hi.delete();
      box_id.delete();
      nb = $urandom_range(5, 20);
      for (int b = 0; b < nb; b++) begin
        make_box(lo, hi);
        box_lo.push_back(lo);
        box_hi.push_back(hi);
        box_id.push_back(16'($urandom));
        send_req(FN_COUNT, pack_req(box_id[b], lo, hi, 13'($urandom)));
      end
      send_idx(FN_FINISH, 0);
      repeat (4) send_idx(FN_READ_CELL, $urandom_range(0, active_cells() + 1));
      for (int b = 0; b < nb; b++) begin
        send_req(FN_PLACE, pack_req(box_id[b], box_lo[b], box_hi[b], 13'($urandom)));
        if ($urandom_range(99) < 15) begin
          case ($urandom_range(3))
            0: send_idx(FN_READ_CELL, $urandom);
            1: send_idx(FN_READ_SLOT, pick_slot());
            2: send_idx($urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B, $urandom);
            default: begin
              make_box(lo, hi);
              send_req(FN_COUNT, pack_req(16'($urandom), lo, hi, 13'($urandom)));
            end
          endcase
        end
      end
      repeat (4) send_idx(FN_READ_SLOT, pick_slot());
      repeat (2) send_idx(FN_READ_CELL, $urandom_range(0, active_cells() - 1));
      no_idle = 1'b0;
    end

    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
rtl/ugb_pkg.sv
rtl/ugb_ram.sv
rtl/ugb_ctrl.sv
rtl/ugb_dp.sv
rtl/uniform_grid_binning.sv
rtl/ugb_checker.sv
tb/sv/ugb_checker.sv
tb/sv/uniform_grid_binning_tb.sv
